// ===== design/prou_pkg.sv =====
// Package for the pixel raster operation unit: drawing mode codes, register
// indexes and the per-byte pixel arithmetic helpers. Depends on nothing.
`timescale 1ns / 1ps

package prou_pkg;

   localparam int PixelWidth = 32;
   localparam int ModeWidth  = 4;
   localparam int CsrIdxWidth = 8;

   typedef logic [PixelWidth-1:0] pixel_type;

   typedef enum logic [ModeWidth-1:0] {
      MODE_COPY   = 4'd0,
      MODE_OVER   = 4'd1,
      MODE_ERASE  = 4'd2,
      MODE_INVERT = 4'd3,
      MODE_ADD    = 4'd4,
      MODE_SUB    = 4'd5,
      MODE_BLEND  = 4'd6,
      MODE_MIN    = 4'd7,
      MODE_MAX    = 4'd8,
      MODE_SELECT = 4'd9
   } op_mode_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_OP_MODE         = 8'd0,
      CSR_BACK_COLOR      = 8'd1,
      CSR_FORE_COLOR      = 8'd2,
      CSR_TRANSPARENT_KEY = 8'd3
   } csr_index_type;

   // Red, green and blue bytes summed; alpha does not count.
   function automatic logic [9:0] pix_energy(input pixel_type p);
      pix_energy = 10'(p[23:16]) + 10'(p[15:8]) + 10'(p[7:0]);
   endfunction

   // Each byte saturates at all ones on its own.
   function automatic pixel_type sat_add(input pixel_type s, input pixel_type d);
      logic [8:0] v;
      sat_add = '0;
      for (int k = 0; k < 4; k++) begin
         v = 9'(s[8*k +: 8]) + 9'(d[8*k +: 8]);
         sat_add[8*k +: 8] = v[8] ? 8'hFF : v[7:0];
      end
   endfunction

   // Each byte is destination minus source, floored at zero.
   function automatic pixel_type sat_sub(input pixel_type s, input pixel_type d);
      logic [8:0] v;
      sat_sub = '0;
      for (int k = 0; k < 4; k++) begin
         v = 9'(d[8*k +: 8]) - 9'(s[8*k +: 8]);
         sat_sub[8*k +: 8] = v[8] ? 8'h00 : v[7:0];
      end
   endfunction

   // Per-byte average, rounded down: the halves plus the AND of both low bits,
   // so no byte can carry into its neighbor.
   function automatic pixel_type half_blend(input pixel_type s, input pixel_type d);
      half_blend = '0;
      for (int k = 0; k < 4; k++) begin
         half_blend[8*k +: 8] = {1'b0, s[8*k+1 +: 7]} + {1'b0, d[8*k+1 +: 7]}
                              + {7'd0, s[8*k] & d[8*k]};
      end
   endfunction

endpackage

// ===== design/pixel_raster_op_unit_top.sv =====
// Top level of the pixel raster operation unit: input register, mode logic
// and result register. Depends on prou_pkg.
`timescale 1ns / 1ps

// The unit combines one source and one destination pixel into one result
// pixel under the drawing mode held in its registers, and accepts a new item
// in every clock cycle while req_stall is low. Each item passes through the
// input register into the result register, which drives the result port,
// and the sustained rate is one item per cycle; the only thing that
// slows it is the result side holding rsp_stall, which fills the two
// registers and then raises req_stall. Registers are written through the
// csr_ port, which is always ready: index 0 is the mode (copy, over, erase,
// invert, add, sub, blend, min, max, select; codes 10 to 15 act as copy),
// 1 the back color, 2 the fore color and 3 the transparent key. Writes to
// other indexes are ignored. Change the registers only while no item is in
// flight, because an item in the input register reads them as it moves to
// the result register.
module pixel_raster_op_unit_top
   import prou_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Input items
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PixelWidth-1:0]  req_src_pixel,
   input  logic [PixelWidth-1:0]  req_dst_pixel,
   // Result items
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PixelWidth-1:0]  rsp_result_pixel,
   // Register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [PixelWidth-1:0]  csr_data
);

   // Configuration registers.
   logic [ModeWidth-1:0] op_mode_ff;
   pixel_type            back_color_ff;
   pixel_type            fore_color_ff;
   pixel_type            transparent_key_ff;

   // Input register.
   logic      in_valid_ff, in_valid_in;
   pixel_type src_ff, dst_ff;

   // Result register.
   logic      out_valid_ff, out_valid_in;
   pixel_type result_ff, result_in;

   logic out_free;
   logic in_load;
   logic in_move;
   logic csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff         <= MODE_COPY;
         back_color_ff      <= '0;
         fore_color_ff      <= '0;
         transparent_key_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_OP_MODE:         op_mode_ff         <= csr_data[ModeWidth-1:0];
            CSR_BACK_COLOR:      back_color_ff      <= csr_data;
            CSR_FORE_COLOR:      fore_color_ff      <= csr_data;
            CSR_TRANSPARENT_KEY: transparent_key_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The result register can take a new item when it is empty or its item is
   // being taken this cycle. The input register then empties into it, and so
   // can take a new item whenever it is empty or moving.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_load) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
   end

   // Mode logic between the two registers.
   always_comb begin
      logic [9:0] src_energy;
      logic [9:0] dst_energy;
      src_energy = pix_energy(src_ff);
      dst_energy = pix_energy(dst_ff);
      if ((op_mode_ff inside {[MODE_ERASE:MODE_SELECT]}) &&
          src_ff == transparent_key_ff) begin
         // A transparent source passes straight through.
         result_in = src_ff;
      end else begin
         case (op_mode_ff)
            MODE_ERASE:  result_in = back_color_ff;
            MODE_INVERT: result_in = ~dst_ff;
            MODE_ADD:    result_in = sat_add(src_ff, dst_ff);
            MODE_SUB:    result_in = sat_sub(src_ff, dst_ff);
            MODE_BLEND:  result_in = half_blend(src_ff, dst_ff);
            MODE_MIN:    result_in = (src_energy < dst_energy) ? src_ff : dst_ff;
            MODE_MAX:    result_in = (src_energy > dst_energy) ? src_ff : dst_ff;
            MODE_SELECT: begin
               if (dst_ff == back_color_ff) begin
                  result_in = fore_color_ff;
               end else if (dst_ff == fore_color_ff) begin
                  result_in = back_color_ff;
               end else begin
                  result_in = transparent_key_ff;
               end
            end
            default:     result_in = src_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         src_ff <= req_src_pixel;
         dst_ff <= req_dst_pixel;
      end
      if (in_move) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_pixel = result_ff;

`ifndef SYNTH
   // The input side is only held off while an item sits in the input register.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall raised with an empty input register");

   // An item leaving the input register always shows up as a result.
   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_free |=> out_valid_ff)
      else $error("item lost between input and result registers");

   // A taken result with nothing behind it leaves the result port empty.
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff && out_valid_ff && !rsp_stall |=> !out_valid_ff)
      else $error("result item repeated");

   // A mode write lands in the mode register.
   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_index == CSR_OP_MODE |=>
         op_mode_ff == $past(csr_data[ModeWidth-1:0]))
      else $error("mode register write lost");
`endif

endmodule

// ===== verif/tb_pixel_raster_op_unit_top.sv =====
// Self-checking testbench for pixel_raster_op_unit_top: directed drawing-mode tests
// followed by randomized traffic under several idle/stall mixes. Depends on prou_pkg.
`timescale 1ns / 1ps

// The bench keeps its own copy of the four registers and computes the
// expected result pixel of every item the unit accepts. Results are checked in
// order against a queue of those expectations. Registers are only rewritten
// once the queue is empty. Every item yields exactly one result, so an empty
// queue means the unit is idle. A watchdog ends the run if nothing moves on
// any channel for too long.
module tb_pixel_raster_op_unit_top;
   import prou_pkg::*;

   // Quiet cycles tolerated before the run is declared hung.
   localparam int StallLimit  = 1000;
   // Cycles to wait after the last result.
   localparam int DrainCycles = 4;
   // Only the first few failures are printed in full.
   localparam int MaxReported = 10;
   // Mode codes past select that the unit treats as copy.
   localparam logic [ModeWidth-1:0] ModeUnusedFirst = 4'd10;
   localparam logic [ModeWidth-1:0] ModeUnusedLast  = 4'd15;
   // A register index with nothing behind it. Writes to it must be ignored.
   localparam logic [CsrIdxWidth-1:0] CsrUnusedIndex = 8'hA5;
   // Byte values that sit on the saturation and rounding boundaries.
   localparam logic [7:0] BoundaryBytes [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};

   logic                   clock;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_stall;
   logic [PixelWidth-1:0]  req_src_pixel = '0;
   logic [PixelWidth-1:0]  req_dst_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_stall     = 1'b0;
   logic [PixelWidth-1:0]  rsp_result_pixel;
   logic                   csr_valid     = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index     = '0;
   logic [PixelWidth-1:0]  csr_data      = '0;

   // One pending result item, with its inputs kept for the failure report.
   typedef struct {
      pixel_type            src;
      pixel_type            dst;
      logic [ModeWidth-1:0] mode;
      pixel_type            result;
   } pending_pixel_type;

   pending_pixel_type pending_results[$];

   // The bench's own view of the unit's registers. These match the reset values.
   logic [ModeWidth-1:0] cur_mode            = '0;
   pixel_type            cur_back_color      = '0;
   pixel_type            cur_fore_color      = '0;
   pixel_type            cur_transparent_key = '0;

   int idle_pct     = 0;   // chance per cycle, in percent, that the sender holds off
   int stall_pct    = 0;   // chance per cycle, in percent, that the receiver stalls
   int failures     = 0;
   int quiet_cycles = 0;

   pixel_raster_op_unit_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_src_pixel   (req_src_pixel),
      .req_dst_pixel   (req_dst_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_pixel(rsp_result_pixel),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Brightness used by min and max. It is the sum of the red, green and blue
   // bytes. Alpha is left out.
   function automatic int rgb_energy(pixel_type p);
      return int'(p[23:16]) + int'(p[15:8]) + int'(p[7:0]);
   endfunction

   function automatic pixel_type predict_result_pixel(pixel_type src, pixel_type dst);
      pixel_type  r;
      logic [8:0] byte_sum;
      logic [7:0] s_b;
      logic [7:0] d_b;
      r = src;
      // A source equal to the key passes straight through in every mode from
      // erase to select. Copy, over and the unused codes never look at the key.
      if (cur_mode >= MODE_ERASE && cur_mode <= MODE_SELECT && src == cur_transparent_key)
         return src;
      case (cur_mode)
         MODE_ERASE:  r = cur_back_color;
         MODE_INVERT: r = ~dst;
         MODE_ADD, MODE_SUB, MODE_BLEND: begin
            for (int k = 0; k < 4; k++) begin
               s_b      = src[8*k +: 8];
               d_b      = dst[8*k +: 8];
               byte_sum = {1'b0, s_b} + {1'b0, d_b};
               if (cur_mode == MODE_ADD)
                  r[8*k +: 8] = byte_sum[8] ? 8'hFF : byte_sum[7:0];
               else if (cur_mode == MODE_SUB)
                  r[8*k +: 8] = (d_b >= s_b) ? d_b - s_b : 8'h00;
               else
                  r[8*k +: 8] = byte_sum[8:1];   // floor of the mean
            end
         end
         // On a tie in brightness, the destination wins in both min and max.
         MODE_MIN:    r = (rgb_energy(src) < rgb_energy(dst)) ? src : dst;
         MODE_MAX:    r = (rgb_energy(src) > rgb_energy(dst)) ? src : dst;
         MODE_SELECT: begin
            if (dst == cur_back_color)
               r = cur_fore_color;
            else if (dst == cur_fore_color)
               r = cur_back_color;
            else
               r = cur_transparent_key;
         end
         default:     r = src;
      endcase
      return r;
   endfunction

   // Random pixel word that lands on all-zero, all-one or boundary bytes often.
   function automatic pixel_type draw_pixel_word();
      pixel_type w;
      w = $urandom();
      case ($urandom_range(0, 7))
         0: w = '0;
         1: w = '1;
         2: for (int k = 0; k < 4; k++) w[8*k +: 8] = BoundaryBytes[$urandom_range(0, 5)];
         default: ;
      endcase
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------

   // Offers one item, after a random hold-off. The task returns in the time
   // step where the item was taken. The valid signal stays high, so the next
   // item can follow without a gap.
   task automatic send_pixels(pixel_type src, pixel_type dst);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_src_pixel <= src;
      req_dst_pixel <= dst;
      do @(posedge clock); while (req_stall);
      pending_results.push_back('{src, dst, cur_mode, predict_result_pixel(src, dst)});
   endtask

   // Stops offering items and waits until every expected result has come back.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // One register write. The write valid is left high for the caller to drop.
   task automatic write_register(logic [CsrIdxWidth-1:0] index, pixel_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_OP_MODE:         cur_mode            = data[ModeWidth-1:0];
         CSR_BACK_COLOR:      cur_back_color      = data;
         CSR_FORE_COLOR:      cur_fore_color      = data;
         CSR_TRANSPARENT_KEY: cur_transparent_key = data;
         default: ;
      endcase
   endtask

   // Rewrites all four registers once the unit has gone idle.
   task automatic configure(logic [ModeWidth-1:0] mode, pixel_type back,
                            pixel_type fore, pixel_type key);
      drain_pipeline();
      write_register(CSR_OP_MODE, 32'(mode));
      write_register(CSR_BACK_COLOR, back);
      write_register(CSR_FORE_COLOR, fore);
      write_register(CSR_TRANSPARENT_KEY, key);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Each result item taken from the unit is compared with the oldest
   // expectation. A result that shows up with nothing pending also counts as a
   // failure.
   always @(posedge clock) begin
      pending_pixel_type exp_item;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= MaxReported)
               $display("%0t: result item %h arrived with nothing expected",
                        $realtime, rsp_result_pixel);
         end else begin
            exp_item = pending_results.pop_front();
            if (rsp_result_pixel !== exp_item.result) begin
               failures++;
               if (failures <= MaxReported)
                  $display("%0t: mode %0d src %h dst %h: expected %h, got %h",
                           $realtime, exp_item.mode, exp_item.src, exp_item.dst,
                           exp_item.result, rsp_result_pixel);
            end
         end
      end
   end

   // Any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < StallLimit) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Out of reset, the mode is copy and the key is zero. A zero source still
   // comes back as the result, because copy ignores the key.
   task automatic test_reset_state();
      send_pixels(32'h0000_0000, 32'hFFFF_FFFF);
      send_pixels(32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   // Copy and over return the source even when it matches the key.
   task automatic test_copy_and_over();
      configure(MODE_COPY, '0, '0, 32'h1234_5678);
      send_pixels(32'h1234_5678, 32'hFFFF_FFFF);
      configure(MODE_OVER, '1, '1, 32'h1234_5678);
      send_pixels(32'h1234_5678, 32'h0000_0000);
      send_pixels(32'hA5A5_A5A5, 32'h5A5A_5A5A);
   endtask

   // Erase gives the back color and invert gives the complement of the
   // destination. In both modes, a keyed source passes through.
   task automatic test_erase_and_invert();
      configure(MODE_ERASE, 32'hC0FF_EE11, '0, 32'h00FF_00FF);
      send_pixels(32'h0000_0001, 32'h0000_0002);
      send_pixels(32'h00FF_00FF, 32'hFFFF_FFFF);
      configure(MODE_INVERT, 32'hC0FF_EE11, '0, 32'h00FF_00FF);
      send_pixels(32'h0000_0000, 32'h0000_0000);
      send_pixels(32'h00FF_00FF, 32'h0000_0000);
   endtask

   // Each byte saturates on its own. The bytes are chosen so that a carry or
   // a borrow would leak into the neighboring byte if one were passed on.
   task automatic test_saturating_add_sub();
      configure(MODE_ADD, '0, '0, 32'hDEAD_BEEF);
      send_pixels(32'h80FF_7F01, 32'h8001_7F00);
      send_pixels(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      configure(MODE_SUB, '0, '0, 32'hDEAD_BEEF);
      send_pixels(32'h10FF_0001, 32'h2000_0000);
      send_pixels(32'hFFFF_FFFF, 32'h0000_0000);
      send_pixels(32'hDEAD_BEEF, 32'h0000_0000);
   endtask

   // The halving blend rounds down. It adds one to the two halves only when both low bits are set.
   task automatic test_halving_blend();
      configure(MODE_BLEND, '0, '0, 32'hDEAD_BEEF);
      send_pixels(32'h01FF_0103, 32'h01FE_0301);
      send_pixels(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixels(32'h0000_0000, 32'hFFFF_FFFF);
   endtask

   // Min and max compare brightness only. The first item in each mode is a
   // tie in brightness between two different pixels, and the destination must win it.
   task automatic test_energy_min_max();
      configure(MODE_MIN, '0, '0, 32'hDEAD_BEEF);
      send_pixels(32'hFF01_0203, 32'h0003_0201);
      send_pixels(32'h0000_0001, 32'hFF00_0000);
      configure(MODE_MAX, '0, '0, 32'hDEAD_BEEF);
      send_pixels(32'hFF01_0203, 32'h0003_0201);
      send_pixels(32'h00FF_FFFF, 32'hFF00_0000);
   endtask

   // Select swaps the back and fore colors. A destination that matches neither
   // gives the key. When back and fore are equal, the back match is checked
   // first, so the result is fore.
   task automatic test_select();
      configure(MODE_SELECT, 32'h1122_3344, 32'h5566_7788, 32'h99AA_BBCC);
      send_pixels(32'h0000_0000, 32'h1122_3344);
      send_pixels(32'h0000_0000, 32'h5566_7788);
      send_pixels(32'h0000_0000, 32'h0000_0000);
      send_pixels(32'h99AA_BBCC, 32'h1122_3344);
      configure(MODE_SELECT, 32'hCAFE_F00D, 32'hCAFE_F00D, '0);
      send_pixels(32'h0000_0001, 32'hCAFE_F00D);
   endtask

   // The unused mode codes act as copy. A write to an index with no register
   // behind it must leave the mode unchanged.
   task automatic test_undefined_modes();
      configure(ModeUnusedLast, '1, '1, '0);
      send_pixels(32'h0000_0000, 32'hFFFF_FFFF);
      drain_pipeline();
      write_register(CsrUnusedIndex, 32'(MODE_ERASE));
      csr_valid <= 1'b0;
      send_pixels(32'h0000_FFFF, 32'h0000_0000);
   endtask

   // Runs a few register settings in turn, with random items under each one.
   // The items are biased toward the cases that decide the result: a source
   // equal to the key, a destination equal to the back or fore color, and a
   // destination with the same brightness as the source.
   task automatic run_random_block(int settings, int items_each);
      logic [ModeWidth-1:0] mode;
      pixel_type            back;
      pixel_type            fore;
      pixel_type            key;
      pixel_type            src;
      pixel_type            dst;
      for (int c = 0; c < settings; c++) begin
         if ($urandom_range(0, 4) == 0)
            mode = 4'($urandom_range(ModeUnusedFirst, ModeUnusedLast));
         else
            mode = 4'($urandom_range(MODE_COPY, MODE_SELECT));
         back = draw_pixel_word();
         fore = ($urandom_range(0, 7) == 0) ? back : draw_pixel_word();
         key  = ($urandom_range(0, 7) == 0) ? back : draw_pixel_word();
         configure(mode, back, fore, key);
         for (int n = 0; n < items_each; n++) begin
            src = draw_pixel_word();
            dst = draw_pixel_word();
            case ($urandom_range(0, 9))
               0: src = cur_transparent_key;
               1: dst = cur_back_color;
               2: dst = cur_fore_color;
               3: dst = {dst[31:24], src[7:0], src[23:16], src[15:8]};
               default: ;
            endcase
            send_pixels(src, dst);
         end
      end
   endtask

   // The random traffic runs in four phases. The first has no gaps or
   // stalls. In the second the sender mostly holds off, and in the third the
   // receiver mostly stalls. In the last, both do so now and then.
   task automatic test_random_traffic();
      idle_pct = 0;  stall_pct = 0;  run_random_block(4, 53);
      idle_pct = 79; stall_pct = 0;  run_random_block(4, 53);
      idle_pct = 0;  stall_pct = 79; run_random_block(4, 53);
      idle_pct = 14; stall_pct = 14; run_random_block(4, 53);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_copy_and_over();
      test_erase_and_invert();
      test_saturating_add_sub();
      test_halving_blend();
      test_energy_min_max();
      test_select();
      test_undefined_modes();
      test_random_traffic();

      // Wait for the last results. Then allow a few more cycles, so that any
      // stray extra item from the unit would still be caught.
      drain_pipeline();
      repeat (DrainCycles) @(posedge clock);

      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
